[src/rhp_pkg.sv]
package rhp_pkg;

    typedef struct packed {
        logic [7:0] header_byte;
        logic       first_byte;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] mapper;
        logic [3:0]  submapper;
        logic [3:0]  cart_flags;
        logic [1:0]  timing;
        logic [31:0] prg_rom_bytes;
        logic [31:0] chr_rom_bytes;
        logic [21:0] prg_ram_bytes;
        logic [21:0] chr_ram_bytes;
        logic [21:0] prg_nvram_bytes;
        logic [21:0] chr_nvram_bytes;
        logic [9:0]  data_offset;
    } out_t;

    localparam logic [1:0] STATUS_BAD_MAGIC = 2'd0;
    localparam logic [1:0] STATUS_V1        = 2'd1;
    localparam logic [1:0] STATUS_V2        = 2'd2;

    localparam logic [1:0] TIMING_NTSC  = 2'd0;
    localparam logic [1:0] TIMING_PAL   = 2'd1;
    localparam logic [1:0] TIMING_DENDY = 2'd2;

    // raw region codes in byte 12 of a 2.0 header
    localparam logic [1:0] REGION_PAL   = 2'd1;
    localparam logic [1:0] REGION_DENDY = 2'd3;

    localparam logic [3:0] LAST_POS    = 4'd15;
    localparam int         MAGIC_LEN   = 4;

    // magic bytes, index 0 first
    localparam logic [3:0][7:0] MAGIC = {8'h1A, 8'h53, 8'h45, 8'h4E};

    localparam logic [9:0]  OFFSET_PLAIN   = 10'd16;
    localparam logic [9:0]  OFFSET_TRAINER = 10'd528;
    localparam logic [21:0] RAM_8K         = 22'd8192;
    localparam logic [31:0] SAT32          = 32'hFFFF_FFFF;
    localparam logic [3:0]  EXP_FORM       = 4'hF;
    localparam logic [3:0]  PRG_UNIT_SHIFT = 4'd14;
    localparam logic [3:0]  CHR_UNIT_SHIFT = 4'd13;

    // 2.0 ROM size: plain (msb:lsb) * unit, or exponent form 2^E * (2M+1) saturated at SAT32
    function automatic logic [31:0] rom_size_v2(input logic [7:0] lsb,
                                                input logic [3:0] msb,
                                                input logic [3:0] unit_shift);
        logic [31:0] plain;
        logic [34:0] wide;
        logic [2:0]  mult;
        logic [31:0] res;
        plain = {20'd0, msb, lsb} << unit_shift;
        mult  = {lsb[1:0], 1'b1};
        wide  = {32'd0, mult} << lsb[6:2];
        if (msb != EXP_FORM) begin
            res = plain;
        end else if (lsb[7] || (wide[34:32] != 3'd0)) begin
            res = SAT32;
        end else begin
            res = wide[31:0];
        end
        return res;
    endfunction

    // 2.0 RAM size: 0 for a zero shift count, else 64 << count
    function automatic logic [21:0] ram_size_v2(input logic [3:0] shift);
        logic [21:0] res;
        if (shift == 4'd0) begin
            res = 22'd0;
        end else begin
            res = 22'd64 << shift;
        end
        return res;
    endfunction

endpackage

[src/rom_header_parser.sv]
// Cartridge header decoder. Feed the 16 header bytes in file order, one word
// per cycle; first_byte restarts the count at any point. The sixteenth byte
// yields one result word, registered, in the cycle after it is taken. Any byte
// may be accepted every cycle: the only stall is a byte offered at the
// sixteenth position, restart-marked or not, while the previous result still
// sits unread in the output register.
// Throughput is one byte per cycle outside that stall; the decode is a single
// combinational stage from the stored header bytes into the result register.
module rom_header_parser (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  rhp_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output rhp_pkg::out_t m_data
);

    logic [3:0]  count_reg;
    logic        magic_reg;
    logic [7:0]  hdr_reg [4:12];
    logic        m_valid_reg;
    rhp_pkg::out_t m_data_reg;

    logic [3:0]  pos;
    logic        accept;
    logic        last_byte;
    logic        byte_ok;
    logic        magic_next;
    rhp_pkg::out_t res;

    assign pos       = s_data.first_byte ? 4'd0 : count_reg;
    assign last_byte = (pos == rhp_pkg::LAST_POS);
    assign s_ready   = !m_valid_reg || m_ready || (count_reg != rhp_pkg::LAST_POS);
    assign accept    = s_valid && s_ready;
    assign byte_ok   = (s_data.header_byte == rhp_pkg::MAGIC[pos[1:0]]);

    always_comb begin
        magic_next = magic_reg;
        if (pos < 4'(rhp_pkg::MAGIC_LEN)) begin
            magic_next = (pos == 4'd0) ? byte_ok : (magic_reg && byte_ok);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 4'd0;
            magic_reg <= 1'b1;
        end else if (accept) begin
            count_reg <= pos + 4'd1;
            magic_reg <= magic_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 4; i <= 12; i++) begin
            if (accept && (pos == 4'(i))) begin
                hdr_reg[i] <= s_data.header_byte;
            end
        end
    end

    // decode from bytes 4..12, all stored before the final byte arrives
    always_comb begin
        res = '0;
        res.data_offset = rhp_pkg::OFFSET_PLAIN;
        if (magic_reg) begin
            res.cart_flags  = hdr_reg[6][3:0];
            res.data_offset = hdr_reg[6][2] ? rhp_pkg::OFFSET_TRAINER
                                            : rhp_pkg::OFFSET_PLAIN;
            if (hdr_reg[7][3:2] == 2'b10) begin
                res.status    = rhp_pkg::STATUS_V2;
                res.mapper    = {hdr_reg[8][3:0], hdr_reg[7][7:4], hdr_reg[6][7:4]};
                res.submapper = hdr_reg[8][7:4];
                case (hdr_reg[12][1:0])
                    rhp_pkg::REGION_PAL:   res.timing = rhp_pkg::TIMING_PAL;
                    rhp_pkg::REGION_DENDY: res.timing = rhp_pkg::TIMING_DENDY;
                    default:               res.timing = rhp_pkg::TIMING_NTSC;
                endcase
                res.prg_rom_bytes   = rhp_pkg::rom_size_v2(hdr_reg[4], hdr_reg[9][3:0],
                                                           rhp_pkg::PRG_UNIT_SHIFT);
                res.chr_rom_bytes   = rhp_pkg::rom_size_v2(hdr_reg[5], hdr_reg[9][7:4],
                                                           rhp_pkg::CHR_UNIT_SHIFT);
                res.prg_ram_bytes   = rhp_pkg::ram_size_v2(hdr_reg[10][3:0]);
                res.chr_ram_bytes   = rhp_pkg::ram_size_v2(hdr_reg[11][3:0]);
                res.prg_nvram_bytes = rhp_pkg::ram_size_v2(hdr_reg[10][7:4]);
                res.chr_nvram_bytes = rhp_pkg::ram_size_v2(hdr_reg[11][7:4]);
            end else begin
                res.status        = rhp_pkg::STATUS_V1;
                res.mapper        = {4'd0, hdr_reg[7][7:4], hdr_reg[6][7:4]};
                res.timing        = hdr_reg[9][0] ? rhp_pkg::TIMING_PAL
                                                  : rhp_pkg::TIMING_NTSC;
                res.prg_rom_bytes = {10'd0, hdr_reg[4], 14'd0};
                res.chr_rom_bytes = {11'd0, hdr_reg[5], 13'd0};
                res.prg_ram_bytes = (hdr_reg[8] != 8'd0) ? {1'b0, hdr_reg[8], 13'd0}
                                                         : rhp_pkg::RAM_8K;
                res.chr_ram_bytes = (hdr_reg[5] == 8'd0) ? rhp_pkg::RAM_8K : 22'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept && last_byte) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && last_byte) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a new result word must never overwrite an unread one
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && last_byte) |-> !(m_valid_reg && !m_ready))
        else $error("result overwritten while stalled");

    // a result word only follows a final header byte
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(accept && last_byte))
        else $error("result without final byte");

    // count wraps to the start of a new header after the final byte
    a_count_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && last_byte) |=> (count_reg == 4'd0))
        else $error("byte count did not wrap");

    // bad magic reports nothing but the plain data offset
    a_bad_magic: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_data_reg.status == rhp_pkg::STATUS_BAD_MAGIC)) |->
        (m_data_reg.data_offset == rhp_pkg::OFFSET_PLAIN &&
         m_data_reg.prg_rom_bytes == 32'd0 && m_data_reg.mapper == 12'd0))
        else $error("bad magic result carries data");

endmodule

[tb/rhp_header_check.sv]
`timescale 1ns / 100ps

module rhp_header_check
    import rhp_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    input  logic  s_ready,
    input  in_t   s_data,
    input  logic  m_valid,
    input  logic  m_ready,
    input  out_t  m_data,
    output int    errors,
    output int    pending,
    output int    checked
);

    logic [3:0] next_pos;
    logic       magic_ok;
    logic [7:0] hdr [13];
    out_t       decoded_q [$];

    function automatic logic [31:0] rom_bytes(input logic [7:0] lsb, input logic [3:0] msb,
                                              input longint unsigned unit);
        longint unsigned v;
        int              e;
        if (msb == EXP_FORM) begin
            e = lsb[7:2];
            if (e >= 32) begin
                return SAT32;
            end
            v = (64'd1 << e) * (2 * lsb[1:0] + 1);
            return (v > 64'hFFFF_FFFF) ? SAT32 : v[31:0];
        end
        v = {msb, lsb} * unit;
        return v[31:0];
    endfunction

    function automatic logic [21:0] ram_bytes(input logic [3:0] shift);
        longint unsigned v;
        if (shift == 4'd0) begin
            return 22'd0;
        end
        v = 64'd64 << shift;
        return v[21:0];
    endfunction

    function automatic out_t decode_header();
        out_t            r;
        logic [7:0]      b4, b5, b6, b7, b8, b9, b10, b11, b12;
        longint unsigned chr;
        b4  = hdr[4];
        b5  = hdr[5];
        b6  = hdr[6];
        b7  = hdr[7];
        b8  = hdr[8];
        b9  = hdr[9];
        b10 = hdr[10];
        b11 = hdr[11];
        b12 = hdr[12];
        r = '0;
        r.data_offset = OFFSET_PLAIN;
        if (!magic_ok) begin
            return r;
        end
        r.cart_flags  = b6[3:0];
        r.data_offset = b6[2] ? OFFSET_TRAINER : OFFSET_PLAIN;
        if (b7[3:2] == 2'b10) begin
            r.status    = STATUS_V2;
            r.mapper    = {b8[3:0], b7[7:4], b6[7:4]};
            r.submapper = b8[7:4];
            // multi-region falls back to NTSC
            if (b12[1:0] == REGION_PAL) begin
                r.timing = TIMING_PAL;
            end else if (b12[1:0] == REGION_DENDY) begin
                r.timing = TIMING_DENDY;
            end else begin
                r.timing = TIMING_NTSC;
            end
            r.prg_rom_bytes   = rom_bytes(b4, b9[3:0], 16384);
            r.chr_rom_bytes   = rom_bytes(b5, b9[7:4], 8192);
            r.prg_ram_bytes   = ram_bytes(b10[3:0]);
            r.chr_ram_bytes   = ram_bytes(b11[3:0]);
            r.prg_nvram_bytes = ram_bytes(b10[7:4]);
            r.chr_nvram_bytes = ram_bytes(b11[7:4]);
        end else begin
            chr               = b5 * 64'd8192;
            r.status          = STATUS_V1;
            r.mapper          = {4'd0, b7[7:4], b6[7:4]};
            r.timing          = b9[0] ? TIMING_PAL : TIMING_NTSC;
            r.prg_rom_bytes   = b4 * 32'd16384;
            r.chr_rom_bytes   = chr[31:0];
            r.prg_ram_bytes   = (b8 != 8'd0) ? b8 * 22'd8192 : RAM_8K;
            r.chr_ram_bytes   = (chr == 0) ? RAM_8K : 22'd0;
        end
        return r;
    endfunction

    function automatic int field_diff(input string fname, input longint unsigned exp_v,
                                      input longint unsigned act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s expected %0d, got %0d", $time, fname, exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    function automatic int result_diff(input out_t e, input out_t a);
        int n;
        n = 0;
        n += field_diff("status", e.status, a.status);
        n += field_diff("mapper", e.mapper, a.mapper);
        n += field_diff("submapper", e.submapper, a.submapper);
        n += field_diff("cart_flags", e.cart_flags, a.cart_flags);
        n += field_diff("timing", e.timing, a.timing);
        n += field_diff("prg_rom_bytes", e.prg_rom_bytes, a.prg_rom_bytes);
        n += field_diff("chr_rom_bytes", e.chr_rom_bytes, a.chr_rom_bytes);
        n += field_diff("prg_ram_bytes", e.prg_ram_bytes, a.prg_ram_bytes);
        n += field_diff("chr_ram_bytes", e.chr_ram_bytes, a.chr_ram_bytes);
        n += field_diff("prg_nvram_bytes", e.prg_nvram_bytes, a.prg_nvram_bytes);
        n += field_diff("chr_nvram_bytes", e.chr_nvram_bytes, a.chr_nvram_bytes);
        n += field_diff("data_offset", e.data_offset, a.data_offset);
        return n;
    endfunction

    always @(posedge aclk) begin
        logic [3:0] pos;
        logic       ok;
        out_t       exp_r;
        if (!aresetn) begin
            next_pos = 4'd0;
            magic_ok = 1'b1;
            decoded_q.delete();
        end else begin
            // retire first so a stray result never meets a fresh prediction
            if (m_valid && m_ready) begin
                if (decoded_q.size() == 0) begin
                    $display("%0t: result word with no header pending, status %0d",
                             $time, m_data.status);
                    errors++;
                end else begin
                    exp_r = decoded_q.pop_front();
                    if (result_diff(exp_r, m_data) != 0) begin
                        errors++;
                    end
                    checked++;
                end
            end
            if (s_valid && s_ready) begin
                pos = s_data.first_byte ? 4'd0 : next_pos;
                if (pos < MAGIC_LEN) begin
                    ok       = (s_data.header_byte == MAGIC[pos[1:0]]);
                    magic_ok = (pos == 4'd0) ? ok : (magic_ok && ok);
                end
                if (pos < 4'd13) begin
                    hdr[pos] = s_data.header_byte;
                end
                next_pos = pos + 4'd1;
                if (pos == LAST_POS) begin
                    decoded_q.push_back(decode_header());
                end
            end
        end
        pending = decoded_q.size();
    end

endmodule

[tb/tb_rom_header_parser.sv]
`timescale 1ns / 100ps

module tb_rom_header_parser;
    import rhp_pkg::*;

    localparam int HDR_V1  = 0;
    localparam int HDR_V2  = 1;
    localparam int HDR_BAD = 2;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic m_ready = 1'b0;
    in_t  s_data  = '0;
    logic s_ready;
    logic m_valid;
    out_t m_data;

    int errors;
    int pending;
    int checked;

    logic [7:0] hdr_buf [16];
    logic       steady = 1'b0;
    int         n_bytes = 0;
    int         n_headers = 0;
    int         n_v1 = 0;
    int         n_v2 = 0;
    int         n_bad = 0;
    int         n_cut = 0;

    always #5 aclk = ~aclk;

    rom_header_parser u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    rhp_header_check u_checker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .errors  (errors),
        .pending (pending),
        .checked (checked)
    );

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        if (steady) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return 8'h00;
        end else if (r == 1) begin
            return 8'hFF;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic f);
        int  gap;
        in_t w;
        gap = idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        w.header_byte = b;
        w.first_byte  = f;
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        n_bytes++;
    endtask

    task automatic send_header(input int len, input logic first0);
        for (int i = 0; i < len; i++) begin
            send_byte(hdr_buf[i], (i == 0) ? first0 : 1'b0);
        end
    endtask

    task automatic make_header(input int kind);
        int v;
        int p;
        for (int i = 0; i < 16; i++) begin
            hdr_buf[i] = (i < MAGIC_LEN) ? MAGIC[i] : pick_byte();
        end
        if (kind == HDR_BAD) begin
            p = $urandom_range(0, 3);
            hdr_buf[p] = hdr_buf[p] ^ 8'($urandom_range(1, 255));
        end
        if (kind == HDR_V2) begin
            hdr_buf[7][3:2] = 2'b10;
            if ($urandom_range(0, 2) == 0) begin
                hdr_buf[9][3:0] = EXP_FORM;
            end
            if ($urandom_range(0, 2) == 0) begin
                hdr_buf[9][7:4] = EXP_FORM;
            end
        end else begin
            v = $urandom_range(0, 2);
            hdr_buf[7][3:2] = (v == 2) ? 2'b11 : 2'(v);
        end
    endtask

    initial begin
        m_ready <= 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            int hold;
            int gap;
            hold = $urandom_range(1, 12);
            m_ready <= 1'b1;
            repeat (hold) @(posedge aclk);
            gap = idle_len();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    initial begin
        int   r;
        int   kind;
        int   len;
        logic first0;
        logic cut_prev;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // header cut short, then restarted by the next one
        make_header(HDR_V1);
        send_header(6, 1'b1);
        n_cut++;

        // 2.0 header: saturating exponent PRG, exponent CHR of one byte,
        // trainer and four-screen, largest mapper, Dendy region, RAM shifts 0, 1 and 15
        make_header(HDR_V2);
        hdr_buf[4]  = 8'hFF;
        hdr_buf[5]  = 8'h00;
        hdr_buf[6]  = 8'hFF;
        hdr_buf[7]  = 8'hF8;
        hdr_buf[8]  = 8'hFF;
        hdr_buf[9]  = 8'hFF;
        hdr_buf[10] = 8'hF1;
        hdr_buf[11] = 8'h0F;
        hdr_buf[12] = 8'h03;
        send_header(16, 1'b1);
        n_headers++;
        n_v2++;

        cut_prev = 1'b0;
        while (n_bytes < 450) begin
            steady = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            kind = (r < 40) ? HDR_V1 : (r < 85) ? HDR_V2 : HDR_BAD;
            make_header(kind);
            // without the mark a fresh header relies on the count wrapping
            first0 = cut_prev ? 1'b1 : ($urandom_range(0, 5) != 0);
            if ($urandom_range(0, 9) == 0) begin
                len = $urandom_range(1, 15);
                cut_prev = 1'b1;
                n_cut++;
            end else begin
                len = 16;
                cut_prev = 1'b0;
                n_headers++;
                if (kind == HDR_V1) begin
                    n_v1++;
                end else if (kind == HDR_V2) begin
                    n_v2++;
                end else begin
                    n_bad++;
                end
            end
            send_header(len, first0);
        end
        s_valid <= 1'b0;

        // let the checker see the last accepted byte before polling
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);

        $display("%0d header bytes sent, %0d full headers: %0d v1, %0d v2.0, %0d bad-magic",
                 n_bytes, n_headers, n_v1, n_v2, n_bad);
        $display("%0d headers cut short by a restart, %0d result words checked",
                 n_cut, checked);
        if (errors == 0) begin
            $display("tb_rom_header_parser OK");
        end else begin
            $display("tb_rom_header_parser NOT OK");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", pending);
        $display("tb_rom_header_parser NOT OK");
        $finish;
    end

endmodule

[files.f]
src/rhp_pkg.sv
src/rom_header_parser.sv
tb/rhp_header_check.sv
tb/tb_rom_header_parser.sv
